FILE: design/sctu_pkg.sv
// ----------------------------------------------------------------------------
// sctu_pkg: shared types, constants and microcode for the sine/cosine unit
// Fixed-point formats, divisor and reciprocal tables, control word layout
// and the sequencer program.
// ----------------------------------------------------------------------------
package sctu_pkg;

	typedef logic signed [31:0] fix_t;
	typedef logic [31:0]        mag_t;
	typedef logic [3:0]         cnt_t;
	typedef logic [4:0]         step_t;
	typedef logic [8:0]         div_t;

	localparam logic [35:0] HALF_PI_Q = 36'd421657428;
	localparam logic [35:0] TWO_Q     = 36'd536870912;
	localparam fix_t        ONE_Q     = 32'sd268435456;
	localparam logic [20:0] OUT_ONE   = 21'd65536;
	localparam logic [63:0] RND_HALF  = 64'd134217728;

	typedef enum logic [3:0] {
		U_NOP,
		U_LOAD,
		U_HALVE,
		U_INIT,
		U_MUL,
		U_RND,
		U_CORR,
		U_ACC,
		U_UPD
	} uop_t;

	typedef enum logic [2:0] {
		OP_R,
		OP_ST,
		OP_CT,
		OP_S,
		OP_C,
		OP_X2,
		OP_N,
		OP_RCP
	} opnd_t;

	typedef enum logic [2:0] {
		D_X2,
		D_U,
		D_V,
		D_W,
		D_N
	} dst_t;

	typedef enum logic {
		SER_SIN,
		SER_COS
	} ser_t;

	typedef enum logic [2:0] {
		J_NEXT,
		J_ALWAYS,
		J_HALVE,
		J_KMORE,
		J_HDONE
	} jmp_t;

	typedef struct packed {
		uop_t  op;
		opnd_t a;
		opnd_t b;
		dst_t  dst;
		ser_t  ser;
		jmp_t  jmp;
		step_t target;
	} ctl_t;

	typedef struct packed {
		logic halve;
		logic k_last;
		logic h_done;
	} sts_t;

	localparam step_t ST_IDLE  = 5'd0;
	localparam step_t ST_HALVE = 5'd1;
	localparam step_t ST_SIN   = 5'd5;
	localparam step_t ST_DTEST = 5'd15;
	localparam step_t ST_OUT   = 5'd23;

	function automatic div_t div_of(ser_t ser, cnt_t k);
		logic [4:0] k2;
		logic [9:0] prod;
		begin
			k2 = {k, 1'b0};
			if (ser == SER_SIN) begin
				prod = 10'(k2) * (10'(k2) + 10'd1);
			end else begin
				prod = 10'(k2) * (10'(k2) - 10'd1);
			end
			return prod[8:0];
		end
	endfunction

	// floor(2^32 / divisor) for each term
	function automatic mag_t recip_of(ser_t ser, cnt_t k);
		mag_t r;
		begin
			r = '0;
			if (ser == SER_SIN) begin
				case (k)
					4'd1:    r = 32'd715827882;
					4'd2:    r = 32'd214748364;
					4'd3:    r = 32'd102261126;
					4'd4:    r = 32'd59652323;
					4'd5:    r = 32'd39045157;
					4'd6:    r = 32'd27531841;
					4'd7:    r = 32'd20452225;
					4'd8:    r = 32'd15790320;
					4'd9:    r = 32'd12558383;
					4'd10:   r = 32'd10226112;
					4'd11:   r = 32'd8488077;
					default: r = '0;
				endcase
			end else begin
				case (k)
					4'd1:    r = 32'd2147483648;
					4'd2:    r = 32'd357913941;
					4'd3:    r = 32'd143165576;
					4'd4:    r = 32'd76695844;
					4'd5:    r = 32'd47721858;
					4'd6:    r = 32'd32537631;
					4'd7:    r = 32'd23598721;
					4'd8:    r = 32'd17895697;
					4'd9:    r = 32'd14035840;
					4'd10:   r = 32'd11302545;
					4'd11:   r = 32'd9296466;
					default: r = '0;
				endcase
			end
			return r;
		end
	endfunction

	function automatic ctl_t cw(uop_t op, opnd_t a, opnd_t b, dst_t dst, ser_t ser,
			jmp_t jmp, step_t target);
		ctl_t c;
		begin
			c.op     = op;
			c.a      = a;
			c.b      = b;
			c.dst    = dst;
			c.ser    = ser;
			c.jmp    = jmp;
			c.target = target;
			return c;
		end
	endfunction

	function automatic ctl_t ucode(step_t addr);
		ctl_t c;
		begin
			unique case (addr)
				5'd0:    c = cw(U_LOAD,  OP_R,  OP_R,   D_X2, SER_SIN, J_NEXT,   ST_IDLE);
				5'd1:    c = cw(U_HALVE, OP_R,  OP_R,   D_X2, SER_SIN, J_HALVE,  ST_HALVE);
				5'd2:    c = cw(U_INIT,  OP_R,  OP_R,   D_X2, SER_SIN, J_NEXT,   ST_IDLE);
				5'd3:    c = cw(U_MUL,   OP_R,  OP_R,   D_X2, SER_SIN, J_NEXT,   ST_IDLE);
				5'd4:    c = cw(U_RND,   OP_R,  OP_R,   D_X2, SER_SIN, J_NEXT,   ST_IDLE);
				5'd5:    c = cw(U_MUL,   OP_ST, OP_X2,  D_X2, SER_SIN, J_NEXT,   ST_IDLE);
				5'd6:    c = cw(U_RND,   OP_R,  OP_R,   D_N,  SER_SIN, J_NEXT,   ST_IDLE);
				5'd7:    c = cw(U_MUL,   OP_N,  OP_RCP, D_X2, SER_SIN, J_NEXT,   ST_IDLE);
				5'd8:    c = cw(U_CORR,  OP_R,  OP_R,   D_X2, SER_SIN, J_NEXT,   ST_IDLE);
				5'd9:    c = cw(U_ACC,   OP_R,  OP_R,   D_X2, SER_SIN, J_NEXT,   ST_IDLE);
				5'd10:   c = cw(U_MUL,   OP_CT, OP_X2,  D_X2, SER_COS, J_NEXT,   ST_IDLE);
				5'd11:   c = cw(U_RND,   OP_R,  OP_R,   D_N,  SER_COS, J_NEXT,   ST_IDLE);
				5'd12:   c = cw(U_MUL,   OP_N,  OP_RCP, D_X2, SER_COS, J_NEXT,   ST_IDLE);
				5'd13:   c = cw(U_CORR,  OP_R,  OP_R,   D_X2, SER_COS, J_NEXT,   ST_IDLE);
				5'd14:   c = cw(U_ACC,   OP_R,  OP_R,   D_X2, SER_COS, J_KMORE,  ST_SIN);
				5'd15:   c = cw(U_NOP,   OP_R,  OP_R,   D_X2, SER_SIN, J_HDONE,  ST_OUT);
				5'd16:   c = cw(U_MUL,   OP_C,  OP_S,   D_X2, SER_SIN, J_NEXT,   ST_IDLE);
				5'd17:   c = cw(U_RND,   OP_R,  OP_R,   D_U,  SER_SIN, J_NEXT,   ST_IDLE);
				5'd18:   c = cw(U_MUL,   OP_C,  OP_C,   D_X2, SER_SIN, J_NEXT,   ST_IDLE);
				5'd19:   c = cw(U_RND,   OP_R,  OP_R,   D_V,  SER_SIN, J_NEXT,   ST_IDLE);
				5'd20:   c = cw(U_MUL,   OP_S,  OP_S,   D_X2, SER_SIN, J_NEXT,   ST_IDLE);
				5'd21:   c = cw(U_RND,   OP_R,  OP_R,   D_W,  SER_SIN, J_NEXT,   ST_IDLE);
				5'd22:   c = cw(U_UPD,   OP_R,  OP_R,   D_X2, SER_SIN, J_ALWAYS, ST_DTEST);
				5'd23:   c = cw(U_NOP,   OP_R,  OP_R,   D_X2, SER_SIN, J_ALWAYS, ST_IDLE);
				default: c = cw(U_NOP,   OP_R,  OP_R,   D_X2, SER_SIN, J_ALWAYS, ST_IDLE);
			endcase
			return c;
		end
	endfunction

endpackage

FILE: design/sctu_datapath.sv
// ----------------------------------------------------------------------------
// sctu_datapath: shared-multiplier datapath of the sine/cosine unit
// Holds the angle, series terms and sums, one registered multiplier, the
// reciprocal divide correction and the double-angle update.
// ----------------------------------------------------------------------------
module sctu_datapath
	import sctu_pkg::*;
#(
	parameter int SERIES_TERMS = 10,
	parameter int MAX_HALVINGS = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ctl_t               ctl,
	input  logic               fire,
	input  logic signed [23:0] angle,
	output sts_t               sts,
	output logic signed [17:0] sine_res,
	output logic signed [17:0] cosine_res
);

	localparam int   LIMIT_I = (MAX_HALVINGS > 12) ? 12 : ((MAX_HALVINGS < 0) ? 0 : MAX_HALVINGS);
	localparam cnt_t LIMIT   = cnt_t'(LIMIT_I);
	localparam cnt_t K_LAST  = cnt_t'(SERIES_TERMS - 1);

	logic [35:0]  red_q;
	logic         neg_q;
	cnt_t         h_q;
	cnt_t         hc_q;
	cnt_t         k_q;
	fix_t         r_q;
	fix_t         x2_q;
	fix_t         st_q;
	fix_t         ct_q;
	fix_t         s_q;
	fix_t         c_q;
	fix_t         u_q;
	fix_t         v_q;
	fix_t         w_q;
	mag_t         n_q;
	logic         tsign_q;
	mag_t         q_q;
	logic [63:0]  p_q;
	logic         psign_q;

	mag_t         a_mag;
	mag_t         b_mag;
	logic         a_neg;
	logic         b_neg;
	div_t         dvs;
	mag_t         rcp;
	logic [63:0]  rsum;
	mag_t         rmag;
	fix_t         rval;
	mag_t         qe;
	logic [40:0]  qd;
	logic [40:0]  rem;
	mag_t         qfix;
	fix_t         acc_val;
	logic [23:0]  ang_mag;
	logic [35:0]  red_c;
	fix_t         r_init;
	logic signed [33:0] ns_w;
	logic signed [33:0] nc_w;

	function automatic mag_t mag_of(fix_t v);
		return v[31] ? mag_t'(-v) : mag_t'(v);
	endfunction

	function automatic fix_t sat_one(logic signed [33:0] v);
		if (v > 34'(ONE_Q)) begin
			return ONE_Q;
		end else if (v < -34'(ONE_Q)) begin
			return -ONE_Q;
		end else begin
			return v[31:0];
		end
	endfunction

	function automatic logic signed [17:0] to_out(fix_t v);
		logic [32:0] t;
		logic [20:0] m;
		begin
			t = {1'b0, mag_of(v)} + 33'd2048;
			m = t[32:12];
			if (m > OUT_ONE) begin
				m = OUT_ONE;
			end
			return v[31] ? -$signed(m[17:0]) : $signed(m[17:0]);
		end
	endfunction

	function automatic void pick(opnd_t o, fix_t r, fix_t st, fix_t ct, fix_t s, fix_t c,
			fix_t x2, mag_t n, mag_t rc, output mag_t m, output logic ng);
		fix_t v;
		begin
			v = '0;
			m = '0;
			ng = 1'b0;
			case (o)
				OP_R:    v = r;
				OP_ST:   v = st;
				OP_CT:   v = ct;
				OP_S:    v = s;
				OP_C:    v = c;
				OP_X2:   v = x2;
				default: v = '0;
			endcase
			if (o == OP_N) begin
				m = n;
			end else if (o == OP_RCP) begin
				m = rc;
			end else begin
				m = mag_of(v);
				ng = v[31];
			end
		end
	endfunction

	always_comb begin
		dvs = div_of(ctl.ser, k_q);
		rcp = recip_of(ctl.ser, k_q);
		pick(ctl.a, r_q, st_q, ct_q, s_q, c_q, x2_q, n_q, rcp, a_mag, a_neg);
		pick(ctl.b, r_q, st_q, ct_q, s_q, c_q, x2_q, n_q, rcp, b_mag, b_neg);

		rsum = p_q + RND_HALF;
		rmag = rsum[59:28];
		rval = psign_q ? -$signed(rmag) : $signed(rmag);

		qe   = p_q[63:32];
		qd   = 41'(qe) * 41'(dvs);
		rem  = {9'b0, n_q} - qd;
		qfix = (rem >= 41'(dvs)) ? qe + 32'd1 : qe;

		acc_val = tsign_q ? $signed(q_q) : -$signed(q_q);

		ang_mag = angle[23] ? 24'(-angle) : 24'(angle);
		red_c   = (red_q > TWO_Q) ? TWO_Q : red_q;
		r_init  = neg_q ? -$signed(red_c[31:0]) : $signed(red_c[31:0]);

		ns_w = 34'(u_q) <<< 1;
		nc_w = 34'(v_q) - 34'(w_q);

		sts.halve  = (red_q > HALF_PI_Q) && (h_q < LIMIT);
		sts.k_last = (k_q == K_LAST);
		sts.h_done = (hc_q == h_q);

		sine_res   = to_out(s_q);
		cosine_res = to_out(c_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q  <= '0;
			hc_q <= '0;
			k_q  <= '0;
		end else if (fire) begin
			case (ctl.op)
				U_LOAD: begin
					h_q <= '0;
				end
				U_HALVE: begin
					if (sts.halve) begin
						h_q <= h_q + 4'd1;
					end
				end
				U_INIT: begin
					k_q  <= 4'd1;
					hc_q <= '0;
				end
				U_ACC: begin
					if (ctl.ser == SER_COS) begin
						k_q <= k_q + 4'd1;
					end
				end
				U_UPD: begin
					hc_q <= hc_q + 4'd1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			case (ctl.op)
				U_LOAD: begin
					red_q <= {ang_mag, 12'b0};
					neg_q <= angle[23];
				end
				U_HALVE: begin
					if (sts.halve) begin
						red_q <= red_q >> 1;
					end
				end
				U_INIT: begin
					r_q  <= r_init;
					st_q <= r_init;
					s_q  <= r_init;
					ct_q <= ONE_Q;
					c_q  <= ONE_Q;
				end
				U_MUL: begin
					p_q     <= 64'(a_mag) * 64'(b_mag);
					psign_q <= a_neg ^ b_neg;
				end
				U_RND: begin
					case (ctl.dst)
						D_X2: x2_q <= rval;
						D_U:  u_q  <= rval;
						D_V:  v_q  <= rval;
						D_W:  w_q  <= rval;
						D_N: begin
							n_q     <= rmag + 32'(dvs >> 1);
							tsign_q <= psign_q;
						end
						default: begin
						end
					endcase
				end
				U_CORR: begin
					q_q <= qfix;
				end
				U_ACC: begin
					if (ctl.ser == SER_SIN) begin
						st_q <= acc_val;
						s_q  <= s_q + acc_val;
					end else begin
						ct_q <= acc_val;
						c_q  <= c_q + acc_val;
					end
				end
				U_UPD: begin
					s_q <= sat_one(ns_w);
					c_q <= sat_one(nc_w);
				end
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: design/sine_cosine_taylor_unit.sv
// ----------------------------------------------------------------------------
// sine_cosine_taylor_unit: sine and cosine of a fixed-point angle
// Microcoded sequencer over one shared multiplier: range reduction by
// halving, Taylor series for both functions, double-angle restoration.
//
//   channel   signals                              direction  format
//   input     in_valid, in_ready, angle            in         Q7.16 signed
//   output    out_valid, out_ready, sine_value,    out        Q1.16 signed
//             cosine_value
//
// Every multiply, the reciprocal divides included, shares the single
// registered 32x32 multiplier. One item at a time; a new angle is taken
// as soon as the previous result sits in the output register. A stalled
// output holds the sequencer at its final step. Reset clears the step
// counter and the output valid flag.
// ----------------------------------------------------------------------------
module sine_cosine_taylor_unit
	import sctu_pkg::*;
#(
	parameter int SERIES_TERMS = 10,
	parameter int MAX_HALVINGS = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [23:0] angle,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [17:0] sine_value,
	output logic signed [17:0] cosine_value
);

	step_t              step_q;
	logic               out_valid_q;
	logic signed [17:0] sine_q;
	logic signed [17:0] cosine_q;

	ctl_t               ctl;
	sts_t               sts;
	logic               fire;
	logic               take;
	logic signed [17:0] sine_res;
	logic signed [17:0] cosine_res;

	sctu_datapath #(
		.SERIES_TERMS(SERIES_TERMS),
		.MAX_HALVINGS(MAX_HALVINGS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.fire      (fire),
		.angle     (angle),
		.sts       (sts),
		.sine_res  (sine_res),
		.cosine_res(cosine_res)
	);

	always_comb begin
		ctl  = ucode(step_q);
		fire = 1'b1;
		if (step_q == ST_IDLE) begin
			fire = in_valid;
		end else if (step_q == ST_OUT) begin
			fire = !out_valid_q || out_ready;
		end
		unique case (ctl.jmp)
			J_NEXT:   take = 1'b0;
			J_ALWAYS: take = 1'b1;
			J_HALVE:  take = sts.halve;
			J_KMORE:  take = !sts.k_last;
			J_HDONE:  take = sts.h_done;
			default:  take = 1'b0;
		endcase
	end

	assign in_ready     = (step_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign sine_value   = sine_q;
	assign cosine_value = cosine_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_IDLE;
			out_valid_q <= 1'b0;
			sine_q      <= '0;
			cosine_q    <= '0;
		end else begin
			if (fire) begin
				step_q <= take ? ctl.target : step_q + 5'd1;
			end
			if (fire && step_q == ST_OUT) begin
				out_valid_q <= 1'b1;
				sine_q      <= sine_res;
				cosine_q    <= cosine_res;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_out_from_final_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(step_q == ST_OUT))
		else $error("output valid raised outside the final step");

	a_step_in_program: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= ST_OUT)
		else $error("step counter left the program");

	a_results_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (sine_q <= 18'sd65536 && sine_q >= -18'sd65536 &&
			cosine_q <= 18'sd65536 && cosine_q >= -18'sd65536))
		else $error("result beyond unit magnitude");

	a_accept_starts_reduction: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (step_q == ST_HALVE))
		else $error("transfer did not start range reduction");

endmodule
